>>> rtl/audio_frame_mixer_with_meters_macros.svh
// Assertion macros for the audio frame mixer checker.
`ifndef AUDIO_FRAME_MIXER_WITH_METERS_MACROS_SVH
`define AUDIO_FRAME_MIXER_WITH_METERS_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define AFM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define AFM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/afm_pkg.sv
// Shared types and constants for the audio frame mixer.
`default_nettype none

package afm_pkg;

   // sample and gain formats
   localparam int SAMPLE_BITS = 16;
   localparam int GAIN_BITS   = 16;
   localparam int GAIN_FRAC   = 12;
   localparam int PEAK_BITS   = 24;
   localparam int SAMPLE_MAX  = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam logic [PEAK_BITS-1:0] PEAK_MAX = '1;
   localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1 << GAIN_FRAC);

   // clip slots
   localparam int MAX_SLOTS          = 4;
   localparam int SLOT_W             = 2;
   localparam int CLIP_SLOTS_DEFAULT = 4;

   // datapath widths
   localparam int OP_B_W = GAIN_BITS + 1;
   localparam int ACC_W  = SAMPLE_BITS + 1 + GAIN_BITS + 1 + SLOT_W;
   localparam int PROD_W = ACC_W + OP_B_W;
   localparam int RND_W  = PROD_W - GAIN_FRAC;

   // stream field layout
   localparam int MIC_L_LSB       = 0;
   localparam int MIC_R_LSB       = MIC_L_LSB + SAMPLE_BITS;
   localparam int CLIP_LSB        = MIC_R_LSB + SAMPLE_BITS;
   localparam int CLIP_STRIDE     = 2 * SAMPLE_BITS;
   localparam int RESET_PEAKS_BIT = CLIP_LSB + MAX_SLOTS * CLIP_STRIDE;
   localparam int REQ_TDATA_W     = ((RESET_PEAKS_BIT + 1 + 7) / 8) * 8;
   localparam int REQ_TUSER_W     = 2;
   localparam int RSP_TDATA_W     = 3 * SAMPLE_BITS + 2 * PEAK_BITS;
   localparam int RSP_TUSER_W     = 1;

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // mic channel codes
   localparam logic [REQ_TUSER_W-1:0] MIC_NONE = 2'd0;
   localparam logic [REQ_TUSER_W-1:0] MIC_MONO = 2'd1;

   typedef enum logic [2:0] {
      REG_CLIP0_GAIN,
      REG_CLIP1_GAIN,
      REG_CLIP2_GAIN,
      REG_CLIP3_GAIN,
      REG_MIC_GAIN,
      REG_MASTER_GAIN,
      REG_PLAYBACK_MODE,
      REG_RECORD_ENABLE
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MIC,
      ST_CLIP_L,
      ST_CLIP_R,
      ST_DRAIN,
      ST_MASTER_L,
      ST_MASTER_R,
      ST_FLUSH1,
      ST_FLUSH2,
      ST_EMIT
   } state_type;

   // what a product in flight is for
   typedef enum logic [2:0] {
      TAG_NONE,
      TAG_MIC,
      TAG_ACC_L,
      TAG_ACC_R,
      TAG_OUT_L,
      TAG_OUT_R
   } tag_type;

   // rounding shift choices
   typedef enum logic [1:0] {
      SH_G,
      SH_G1,
      SH_2G,
      SH_2G1
   } shift_type;

   typedef struct packed {
      logic    req_ready;
      tag_type issue;
      logic    slot_next;
      logic    emit;
   } ctrl_type;

endpackage

`default_nettype wire

>>> rtl/audio_frame_mixer_with_meters.sv
// Audio frame mixer: clip mix, master gain, limiter, mic gain and peak meters.
//
// Input stream (req_*): one audio frame per transfer; mic pair, one stereo
// sample per clip slot and a peak clear flag. Result stream (rsp_*): mixed
// stereo output, recording sample with its valid flag, and both held peaks.
// The user must write gains and modes through the csr_* register port only
// while idle; the block itself does not enforce this.
//
// All products come from one shared multiplier, one per cycle, under a small
// sequencer: mic (when a mic is present), then every clip slot (two products
// per slot in stereo, one in mono), then a drain state, then master gain per
// output channel in stereo and once in mono, then flush states for rounding
// and metering. req_tready is high only while the sequencer is idle. A finished
// result sits in the output register; the next frame is accepted and worked
// on, and only waits at the end while the previous result is stalled by
// rsp_tready. Reset loads the default gains, clears modes and both held
// peaks, and drops rsp_tvalid.
`default_nettype none

module audio_frame_mixer_with_meters import afm_pkg::*; #(
   parameter int CLIP_SLOTS = CLIP_SLOTS_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   // mic_left, mic_right, clip0_left, clip0_right, ... clip3_right, reset_peaks
   input  wire [REQ_TDATA_W-1:0]  req_tdata,
   // mic_channels
   input  wire [REQ_TUSER_W-1:0]  req_tuser,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // out_left, out_right, rec_sample, mic_peak, master_peak
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // rec_valid
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire                    csr_psel,
   input  wire                    csr_penable,
   input  wire                    csr_pwrite,
   input  wire [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam logic signed [RND_W-1:0] OUT_HI = RND_W'(SAMPLE_MAX);
   localparam logic signed [RND_W-1:0] OUT_LO = RND_W'(-SAMPLE_MAX - 1);
   localparam logic signed [RND_W-1:0] REC_LO = RND_W'(-SAMPLE_MAX);

   // configuration
   logic [GAIN_BITS-1:0] gain_ff [MAX_SLOTS];
   logic [GAIN_BITS-1:0] gain_in [MAX_SLOTS];
   logic [GAIN_BITS-1:0] mic_gain_ff, mic_gain_in;
   logic [GAIN_BITS-1:0] master_gain_ff, master_gain_in;
   logic                 mode_ff, mode_in;
   logic                 rec_en_ff, rec_en_in;

   // sequencer
   state_type            state_ff, state_in;
   ctrl_type             ctrl;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 last_slot;

   // captured frame
   logic signed [SAMPLE_BITS-1:0] mic_l_ff, mic_l_in, mic_r_ff, mic_r_in;
   logic [REQ_TUSER_W-1:0]        chans_ff, chans_in;
   logic signed [SAMPLE_BITS-1:0] clip_l_ff [MAX_SLOTS];
   logic signed [SAMPLE_BITS-1:0] clip_l_in [MAX_SLOTS];
   logic signed [SAMPLE_BITS-1:0] clip_r_ff [MAX_SLOTS];
   logic signed [SAMPLE_BITS-1:0] clip_r_in [MAX_SLOTS];

   // shared multiplier and pipeline
   logic signed [SAMPLE_BITS:0]   mic_sum, clip_l_x, clip_r_x, clip_sum;
   logic signed [ACC_W-1:0]       op_a;
   logic signed [OP_B_W-1:0]      op_b;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   tag_type                       prod_tag_ff, prod_tag_in;
   logic signed [ACC_W-1:0]       acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;

   // rounding stage
   shift_type                     sh_sel;
   logic signed [PROD_W-1:0]      half, neg_adj, biased, shifted;
   logic signed [RND_W-1:0]       rnd_ff, rnd_in;
   tag_type                       rnd_tag_ff, rnd_tag_in;

   // metering and limiting stage
   logic [RND_W-1:0]              rnd_mag;
   logic [PEAK_BITS-1:0]          rnd_peak;
   logic signed [SAMPLE_BITS-1:0] out_clamp, rec_clamp;
   logic [PEAK_BITS-1:0]          mic_peak_ff, mic_peak_in;
   logic [PEAK_BITS-1:0]          master_peak_ff, master_peak_in;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;
   logic signed [SAMPLE_BITS-1:0] rec_ff, rec_in;
   logic                          rec_valid_ff, rec_valid_in;

   // output register
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic          req_accept, csr_wr;
   reg_index_type csr_index;

   assign last_slot  = (slot_ff == SLOT_W'(CLIP_SLOTS - 1));
   assign req_accept = req_tvalid & ctrl.req_ready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   assign req_tready = ctrl.req_ready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign csr_pready = 1'b1;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_MIC;
         ST_MIC:      state_in = ST_CLIP_L;
         ST_CLIP_L: begin
            if (!mode_ff) state_in = ST_CLIP_R;
            else if (last_slot) state_in = ST_DRAIN;
         end
         ST_CLIP_R:   state_in = last_slot ? ST_DRAIN : ST_CLIP_L;
         ST_DRAIN:    state_in = ST_MASTER_L;
         ST_MASTER_L: state_in = mode_ff ? ST_FLUSH1 : ST_MASTER_R;
         ST_MASTER_R: state_in = ST_FLUSH1;
         ST_FLUSH1:   state_in = ST_FLUSH2;
         ST_FLUSH2:   state_in = ST_EMIT;
         ST_EMIT:     if (ctrl.emit) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '{req_ready: 1'b0, issue: TAG_NONE, slot_next: 1'b0, emit: 1'b0};
      case (state_ff)
         ST_IDLE:     ctrl.req_ready = 1'b1;
         ST_MIC:      if (chans_ff != MIC_NONE) ctrl.issue = TAG_MIC;
         ST_CLIP_L: begin
            ctrl.issue     = TAG_ACC_L;
            ctrl.slot_next = mode_ff & ~last_slot;
         end
         ST_CLIP_R: begin
            ctrl.issue     = TAG_ACC_R;
            ctrl.slot_next = ~last_slot;
         end
         ST_MASTER_L: ctrl.issue = TAG_OUT_L;
         ST_MASTER_R: ctrl.issue = TAG_OUT_R;
         ST_EMIT:     ctrl.emit  = ~rsp_tvalid_ff | rsp_tready;
         default:     ;
      endcase
   end

   // ---------------------------------------------------------------- operands
   always_comb begin
      mic_sum  = {mic_l_ff[SAMPLE_BITS-1], mic_l_ff} +
                 ((chans_ff == MIC_MONO) ? '0 : {mic_r_ff[SAMPLE_BITS-1], mic_r_ff});
      clip_l_x = {clip_l_ff[slot_ff][SAMPLE_BITS-1], clip_l_ff[slot_ff]};
      clip_r_x = {clip_r_ff[slot_ff][SAMPLE_BITS-1], clip_r_ff[slot_ff]};
      clip_sum = clip_l_x + (mode_ff ? clip_r_x : '0);
      op_a = '0;
      op_b = '0;
      case (ctrl.issue)
         TAG_MIC: begin
            op_a = ACC_W'(mic_sum);
            op_b = {1'b0, mic_gain_ff};
         end
         TAG_ACC_L: begin
            op_a = ACC_W'(clip_sum);
            op_b = {1'b0, gain_ff[slot_ff]};
         end
         TAG_ACC_R: begin
            op_a = ACC_W'(clip_r_x);
            op_b = {1'b0, gain_ff[slot_ff]};
         end
         TAG_OUT_L: begin
            op_a = acc_l_ff;
            op_b = {1'b0, master_gain_ff};
         end
         TAG_OUT_R: begin
            op_a = acc_r_ff;
            op_b = {1'b0, master_gain_ff};
         end
         default: ;
      endcase
      prod_in = op_a * op_b;
   end

   // ---------------------------------------------------------------- rounding
   // round half away from zero: (v + half - (v < 0)) >>> shift
   always_comb begin
      sh_sel = SH_G;
      case (prod_tag_ff)
         TAG_MIC:              sh_sel = (chans_ff == MIC_MONO) ? SH_G : SH_G1;
         TAG_OUT_L, TAG_OUT_R: sh_sel = mode_ff ? SH_2G1 : SH_2G;
         default:              sh_sel = SH_G;
      endcase
      case (sh_sel)
         SH_G:    half = PROD_W'(1) << (GAIN_FRAC - 1);
         SH_G1:   half = PROD_W'(1) << GAIN_FRAC;
         SH_2G:   half = PROD_W'(1) << (2 * GAIN_FRAC - 1);
         SH_2G1:  half = PROD_W'(1) << (2 * GAIN_FRAC);
         default: half = '0;
      endcase
      neg_adj = prod_ff[PROD_W-1] ? '1 : '0;
      biased  = prod_ff + half + neg_adj;
      case (sh_sel)
         SH_G:    shifted = biased >>> GAIN_FRAC;
         SH_G1:   shifted = biased >>> (GAIN_FRAC + 1);
         SH_2G:   shifted = biased >>> (2 * GAIN_FRAC);
         SH_2G1:  shifted = biased >>> (2 * GAIN_FRAC + 1);
         default: shifted = biased;
      endcase
      rnd_in = shifted[RND_W-1:0];
      case (prod_tag_ff)
         TAG_MIC, TAG_OUT_L, TAG_OUT_R: rnd_tag_in = prod_tag_ff;
         default:                       rnd_tag_in = TAG_NONE;
      endcase
   end

   // ---------------------------------------------------------------- metering
   always_comb begin
      rnd_mag  = rnd_ff[RND_W-1] ? RND_W'(-rnd_ff) : rnd_ff;
      rnd_peak = (|rnd_mag[RND_W-1:PEAK_BITS]) ? PEAK_MAX : rnd_mag[PEAK_BITS-1:0];
      if (rnd_ff > OUT_HI)      out_clamp = OUT_HI[SAMPLE_BITS-1:0];
      else if (rnd_ff < OUT_LO) out_clamp = OUT_LO[SAMPLE_BITS-1:0];
      else                      out_clamp = rnd_ff[SAMPLE_BITS-1:0];
      if (rnd_ff > OUT_HI)      rec_clamp = OUT_HI[SAMPLE_BITS-1:0];
      else if (rnd_ff < REC_LO) rec_clamp = REC_LO[SAMPLE_BITS-1:0];
      else                      rec_clamp = rnd_ff[SAMPLE_BITS-1:0];
   end

   // ---------------------------------------------------------------- next values
   always_comb begin
      gain_in        = gain_ff;
      mic_gain_in    = mic_gain_ff;
      master_gain_in = master_gain_ff;
      mode_in        = mode_ff;
      rec_en_in      = rec_en_ff;
      slot_in        = slot_ff;
      mic_l_in       = mic_l_ff;
      mic_r_in       = mic_r_ff;
      chans_in       = chans_ff;
      clip_l_in      = clip_l_ff;
      clip_r_in      = clip_r_ff;
      acc_l_in       = acc_l_ff;
      acc_r_in       = acc_r_ff;
      mic_peak_in    = mic_peak_ff;
      master_peak_in = master_peak_ff;
      out_l_in       = out_l_ff;
      out_r_in       = out_r_ff;
      rec_in         = rec_ff;
      rec_valid_in   = rec_valid_ff;
      prod_tag_in    = ctrl.issue;

      if (csr_wr) begin
         case (csr_index)
            REG_CLIP0_GAIN:    gain_in[0]     = csr_pwdata[GAIN_BITS-1:0];
            REG_CLIP1_GAIN:    gain_in[1]     = csr_pwdata[GAIN_BITS-1:0];
            REG_CLIP2_GAIN:    gain_in[2]     = csr_pwdata[GAIN_BITS-1:0];
            REG_CLIP3_GAIN:    gain_in[3]     = csr_pwdata[GAIN_BITS-1:0];
            REG_MIC_GAIN:      mic_gain_in    = csr_pwdata[GAIN_BITS-1:0];
            REG_MASTER_GAIN:   master_gain_in = csr_pwdata[GAIN_BITS-1:0];
            REG_PLAYBACK_MODE: mode_in        = csr_pwdata[0];
            REG_RECORD_ENABLE: rec_en_in      = csr_pwdata[0];
            default:           ;
         endcase
      end

      if (req_accept) begin
         mic_l_in = req_tdata[MIC_L_LSB +: SAMPLE_BITS];
         mic_r_in = req_tdata[MIC_R_LSB +: SAMPLE_BITS];
         chans_in = req_tuser;
         for (int k = 0; k < MAX_SLOTS; k++) begin
            clip_l_in[k] = req_tdata[CLIP_LSB + k * CLIP_STRIDE +: SAMPLE_BITS];
            clip_r_in[k] = req_tdata[CLIP_LSB + k * CLIP_STRIDE + SAMPLE_BITS +: SAMPLE_BITS];
         end
         slot_in      = '0;
         acc_l_in     = '0;
         acc_r_in     = '0;
         rec_in       = '0;
         rec_valid_in = rec_en_ff & (req_tuser != MIC_NONE);
         if (req_tdata[RESET_PEAKS_BIT]) begin
            mic_peak_in    = '0;
            master_peak_in = '0;
         end
      end else if (ctrl.slot_next) begin
         slot_in = slot_ff + SLOT_W'(1);
      end

      case (prod_tag_ff)
         TAG_ACC_L: acc_l_in = acc_l_ff + $signed(prod_ff[ACC_W-1:0]);
         TAG_ACC_R: acc_r_in = acc_r_ff + $signed(prod_ff[ACC_W-1:0]);
         default:   ;
      endcase

      case (rnd_tag_ff)
         TAG_MIC: begin
            if (rnd_peak > mic_peak_ff) mic_peak_in = rnd_peak;
            if (rec_valid_ff) rec_in = rec_clamp;
         end
         TAG_OUT_L: begin
            if (rnd_peak > master_peak_ff) master_peak_in = rnd_peak;
            out_l_in = out_clamp;
            if (mode_ff) out_r_in = out_clamp;
         end
         TAG_OUT_R: begin
            if (rnd_peak > master_peak_ff) master_peak_in = rnd_peak;
            out_r_in = out_clamp;
         end
         default: ;
      endcase

      rsp_tvalid_in = ctrl.emit | (rsp_tvalid_ff & ~rsp_tready);
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (ctrl.emit) begin
         rsp_tdata_in = {master_peak_ff, mic_peak_ff, rec_ff, out_r_ff, out_l_ff};
         rsp_tuser_in = rec_valid_ff;
      end
   end

   // register read
   always_comb begin
      case (csr_index)
         REG_CLIP0_GAIN:    csr_prdata = CSR_DATA_W'(gain_ff[0]);
         REG_CLIP1_GAIN:    csr_prdata = CSR_DATA_W'(gain_ff[1]);
         REG_CLIP2_GAIN:    csr_prdata = CSR_DATA_W'(gain_ff[2]);
         REG_CLIP3_GAIN:    csr_prdata = CSR_DATA_W'(gain_ff[3]);
         REG_MIC_GAIN:      csr_prdata = CSR_DATA_W'(mic_gain_ff);
         REG_MASTER_GAIN:   csr_prdata = CSR_DATA_W'(master_gain_ff);
         REG_PLAYBACK_MODE: csr_prdata = CSR_DATA_W'(mode_ff);
         REG_RECORD_ENABLE: csr_prdata = CSR_DATA_W'(rec_en_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_SLOTS; k++) gain_ff[k] <= GAIN_UNITY;
         mic_gain_ff    <= GAIN_UNITY;
         master_gain_ff <= GAIN_UNITY;
         mode_ff        <= 1'b0;
         rec_en_ff      <= 1'b0;
         state_ff       <= ST_IDLE;
         slot_ff        <= '0;
         prod_tag_ff    <= TAG_NONE;
         rnd_tag_ff     <= TAG_NONE;
         mic_peak_ff    <= '0;
         master_peak_ff <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         gain_ff        <= gain_in;
         mic_gain_ff    <= mic_gain_in;
         master_gain_ff <= master_gain_in;
         mode_ff        <= mode_in;
         rec_en_ff      <= rec_en_in;
         state_ff       <= state_in;
         slot_ff        <= slot_in;
         prod_tag_ff    <= prod_tag_in;
         rnd_tag_ff     <= rnd_tag_in;
         mic_peak_ff    <= mic_peak_in;
         master_peak_ff <= master_peak_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mic_l_ff     <= mic_l_in;
      mic_r_ff     <= mic_r_in;
      chans_ff     <= chans_in;
      clip_l_ff    <= clip_l_in;
      clip_r_ff    <= clip_r_in;
      prod_ff      <= prod_in;
      acc_l_ff     <= acc_l_in;
      acc_r_ff     <= acc_r_in;
      rnd_ff       <= rnd_in;
      out_l_ff     <= out_l_in;
      out_r_ff     <= out_r_in;
      rec_ff       <= rec_in;
      rec_valid_ff <= rec_valid_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

endmodule

`default_nettype wire

>>> rtl/afm_checker.sv
// Port-level checker for the audio frame mixer, bound to the top level.
`default_nettype none
`include "audio_frame_mixer_with_meters_macros.svh"

module afm_checker import afm_pkg::*; (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tvalid,
   input wire                    req_tready,
   input wire [RSP_TDATA_W-1:0]  rsp_tdata,
   input wire [RSP_TUSER_W-1:0]  rsp_tuser,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready
);

   localparam int REC_LSB = 2 * SAMPLE_BITS;
   localparam logic [SAMPLE_BITS-1:0] REC_FORBIDDEN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic [SAMPLE_BITS-1:0] rec_field;
   assign rec_field = rsp_tdata[REC_LSB +: SAMPLE_BITS];

   // stalled result holds
   `AFM_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // one frame at a time: busy right after a transfer
   `AFM_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "input taken while busy")

   // no recording sample without its valid flag
   `AFM_ASSERT_NOW(a_rec_zero, rsp_tvalid && !rsp_tuser[0], rec_field == '0, "rec_sample nonzero while rec_valid low")

   // recording sample is symmetric, never negative full scale
   `AFM_ASSERT_NOW(a_rec_range, rsp_tvalid, rec_field != REC_FORBIDDEN, "rec_sample at negative full scale")

endmodule

bind audio_frame_mixer_with_meters afm_checker u_afm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

>>> bench/audio_frame_mixer_with_meters_checker.sv
`timescale 1ns / 1ps
// Mixer checker: follows register writes, predicts each frame's mix and compares results.
module audio_frame_mixer_with_meters_checker import afm_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                   csr_pready,
   output int                     mismatches,
   output int                     mixes_due
);

   localparam longint OUT_MAX = SAMPLE_MAX;
   localparam longint OUT_MIN = -SAMPLE_MAX - 1;

   // result field offsets in rsp_tdata
   localparam int RSP_LEFT_LSB   = 0;
   localparam int RSP_RIGHT_LSB  = SAMPLE_BITS;
   localparam int RSP_REC_LSB    = 2 * SAMPLE_BITS;
   localparam int RSP_MIC_PK_LSB = 3 * SAMPLE_BITS;
   localparam int RSP_MST_PK_LSB = RSP_MIC_PK_LSB + PEAK_BITS;

   typedef struct {
      longint left;
      longint right;
      longint rec;
      longint rec_ok;
      longint mic_pk;
      longint mst_pk;
   } mix_out_type;

   logic [GAIN_BITS-1:0] clip_gain [MAX_SLOTS];
   logic [GAIN_BITS-1:0] mic_gain;
   logic [GAIN_BITS-1:0] master_gain;
   logic                 mono_mix;
   logic                 recording;
   logic [PEAK_BITS-1:0] mic_hold;
   logic [PEAK_BITS-1:0] master_hold;
   mix_out_type          pending_mixes [$];

   // nearest sample step, ties away from zero
   function automatic longint round_q(input longint v, input int sh);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (longint'(1) << (sh - 1))) >> sh;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [PEAK_BITS-1:0] fold_peak(input logic [PEAK_BITS-1:0] held,
                                                       input longint m);
      if (m > longint'(PEAK_MAX))
         m = longint'(PEAK_MAX);
      return (m > longint'(held)) ? PEAK_BITS'(m) : held;
   endfunction

   function automatic mix_out_type mix_frame(input logic [REQ_TDATA_W-1:0] frame,
                                             input logic [REQ_TUSER_W-1:0] chans);
      mix_out_type r;
      longint   mic_l, mic_r, mic_v, cl, cr, g, acc_l, acc_r, out_l, out_r;
      acc_l    = 0;
      acc_r    = 0;
      r.rec    = 0;
      r.rec_ok = 0;
      if (frame[RESET_PEAKS_BIT]) begin
         mic_hold    = '0;
         master_hold = '0;
      end

      if (chans != MIC_NONE) begin
         mic_l = longint'($signed(frame[MIC_L_LSB +: SAMPLE_BITS]));
         mic_r = longint'($signed(frame[MIC_R_LSB +: SAMPLE_BITS]));
         if (chans == MIC_MONO)
            mic_v = round_q(mic_l * longint'(mic_gain), GAIN_FRAC);
         else
            mic_v = round_q((mic_l + mic_r) * longint'(mic_gain), GAIN_FRAC + 1);
         mic_hold = fold_peak(mic_hold, mag(mic_v));
         if (recording) begin
            r.rec_ok = 1;
            r.rec    = clamp(mic_v, -SAMPLE_MAX, SAMPLE_MAX);
         end
      end

      for (int k = 0; k < CLIP_SLOTS_DEFAULT; k++) begin
         cl = longint'($signed(frame[CLIP_LSB + k * CLIP_STRIDE +: SAMPLE_BITS]));
         cr = longint'($signed(frame[CLIP_LSB + k * CLIP_STRIDE + SAMPLE_BITS +: SAMPLE_BITS]));
         g  = longint'(clip_gain[k]);
         if (mono_mix) begin
            acc_l += (cl + cr) * g;
         end else begin
            acc_l += cl * g;
            acc_r += cr * g;
         end
      end

      // mono halves the downmix in the same rounding step
      if (mono_mix) begin
         out_l = round_q(acc_l * longint'(master_gain), 2 * GAIN_FRAC + 1);
         out_r = out_l;
      end else begin
         out_l = round_q(acc_l * longint'(master_gain), 2 * GAIN_FRAC);
         out_r = round_q(acc_r * longint'(master_gain), 2 * GAIN_FRAC);
      end
      master_hold = fold_peak(master_hold, (mag(out_l) > mag(out_r)) ? mag(out_l) : mag(out_r));

      r.left   = clamp(out_l, OUT_MIN, OUT_MAX);
      r.right  = clamp(out_r, OUT_MIN, OUT_MAX);
      r.mic_pk = mic_hold;
      r.mst_pk = master_hold;
      return r;
   endfunction

   function automatic void write_setting(input reg_index_type idx,
                                         input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_CLIP0_GAIN:    clip_gain[0] = data[GAIN_BITS-1:0];
         REG_CLIP1_GAIN:    clip_gain[1] = data[GAIN_BITS-1:0];
         REG_CLIP2_GAIN:    clip_gain[2] = data[GAIN_BITS-1:0];
         REG_CLIP3_GAIN:    clip_gain[3] = data[GAIN_BITS-1:0];
         REG_MIC_GAIN:      mic_gain     = data[GAIN_BITS-1:0];
         REG_MASTER_GAIN:   master_gain  = data[GAIN_BITS-1:0];
         REG_PLAYBACK_MODE: mono_mix     = data[0];
         REG_RECORD_ENABLE: recording    = data[0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      mix_out_type want;
      if (reset) begin
         for (int k = 0; k < MAX_SLOTS; k++)
            clip_gain[k] = GAIN_UNITY;
         mic_gain    = GAIN_UNITY;
         master_gain = GAIN_UNITY;
         mono_mix    = 1'b0;
         recording   = 1'b0;
         mic_hold    = '0;
         master_hold = '0;
         mismatches  = 0;
         pending_mixes.delete();
      end else begin
         // compare before queueing so a same-edge frame cannot cover a stray result
         if (rsp_tvalid && rsp_tready) begin
            if (pending_mixes.size() == 0) begin
               $display("%0t ns: result transfer with no frame waiting, expected none, got %h",
                        $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_mixes.pop_front();
               check_field("out_left", want.left,
                           longint'($signed(rsp_tdata[RSP_LEFT_LSB +: SAMPLE_BITS])));
               check_field("out_right", want.right,
                           longint'($signed(rsp_tdata[RSP_RIGHT_LSB +: SAMPLE_BITS])));
               check_field("rec_sample", want.rec,
                           longint'($signed(rsp_tdata[RSP_REC_LSB +: SAMPLE_BITS])));
               check_field("rec_valid", want.rec_ok, longint'(rsp_tuser[0]));
               check_field("mic_peak", want.mic_pk,
                           longint'(rsp_tdata[RSP_MIC_PK_LSB +: PEAK_BITS]));
               check_field("master_peak", want.mst_pk,
                           longint'(rsp_tdata[RSP_MST_PK_LSB +: PEAK_BITS]));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_setting(reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]), csr_pwdata);
         if (req_tvalid && req_tready)
            pending_mixes.insert(pending_mixes.size(), mix_frame(req_tdata, req_tuser));
      end
      mixes_due = pending_mixes.size();
   end

endmodule

>>> bench/audio_frame_mixer_with_meters_tb.sv
`timescale 1ns / 1ps
// Mixer testbench top: drives frames and register writes, gives the verdict.
module audio_frame_mixer_with_meters_tb;
   import afm_pkg::*;

   localparam int FRAME_PHASES     = 10;
   localparam int FRAMES_PER_PHASE = 200;
   localparam int HOLD_OFF_CYCLES  = 500;
   localparam int SETTLE_CYCLES    = 40;

   // channel counts beyond the package's codes
   localparam logic [REQ_TUSER_W-1:0] MIC_PAIR  = 2'd2;
   localparam logic [REQ_TUSER_W-1:0] MIC_EXTRA = 2'd3;

   logic                   clock;
   logic                   reset;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;
   int                     mismatches;
   int                     mixes_due;
   int                     frames_sent;

   audio_frame_mixer_with_meters uut (.*);

   audio_frame_mixer_with_meters_checker mix_check (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** audio_frame_mixer_with_meters: FAILED **");
      $finish;
   end

   function automatic logic [REQ_TDATA_W-1:0] uniform_frame(
      input logic [SAMPLE_BITS-1:0] mic_l, mic_r, clip_l, clip_r,
      input logic clear);
      logic [REQ_TDATA_W-1:0] f;
      f = '0;
      f[MIC_L_LSB +: SAMPLE_BITS] = mic_l;
      f[MIC_R_LSB +: SAMPLE_BITS] = mic_r;
      for (int k = 0; k < MAX_SLOTS; k++) begin
         f[CLIP_LSB + k * CLIP_STRIDE +: SAMPLE_BITS]               = clip_l;
         f[CLIP_LSB + k * CLIP_STRIDE + SAMPLE_BITS +: SAMPLE_BITS] = clip_r;
      end
      f[RESET_PEAKS_BIT] = clear;
      return f;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return '0;
         3: return SAMPLE_BITS'($urandom_range(0, 512) - 256);
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [GAIN_BITS-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return GAIN_UNITY;
         3: return GAIN_BITS'($urandom_range(0, 8192));
         default: return GAIN_BITS'($urandom);
      endcase
   endfunction

   // idle slots send zeros, so leave some slots silent
   function automatic logic [REQ_TDATA_W-1:0] random_frame();
      logic [REQ_TDATA_W-1:0] f;
      f = uniform_frame(pick_sample(), pick_sample(), '0, '0, $urandom_range(0, 15) == 0);
      for (int k = 0; k < MAX_SLOTS; k++)
         if ($urandom_range(0, 5) != 0) begin
            f[CLIP_LSB + k * CLIP_STRIDE +: SAMPLE_BITS]               = pick_sample();
            f[CLIP_LSB + k * CLIP_STRIDE + SAMPLE_BITS +: SAMPLE_BITS] = pick_sample();
         end
      return f;
   endfunction

   task automatic send_frame(input logic [REQ_TDATA_W-1:0] data,
                             input logic [REQ_TUSER_W-1:0] chans, input int gap);
      @(negedge clock);
      req_tdata  = data;
      req_tuser  = chans;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      frames_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      if (req_tvalid) begin
         @(negedge clock);
         req_tvalid = 1'b0;
      end
      do @(negedge clock); while (mixes_due != 0);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [GAIN_BITS-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {16'($urandom), value};   // upper bits are don't-care
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic load_setup(input logic [GAIN_BITS-1:0] c0, c1, c2, c3, mic, master,
                             input logic mono, rec);
      write_reg(REG_CLIP0_GAIN, c0);
      write_reg(REG_CLIP1_GAIN, c1);
      write_reg(REG_CLIP2_GAIN, c2);
      write_reg(REG_CLIP3_GAIN, c3);
      write_reg(REG_MIC_GAIN, mic);
      write_reg(REG_MASTER_GAIN, master);
      write_reg(REG_PLAYBACK_MODE, GAIN_BITS'(mono));
      write_reg(REG_RECORD_ENABLE, GAIN_BITS'(rec));
   endtask

   // receiver: stall patterns in stretches, plus one long hold-off under load
   initial begin : result_sink
      int stretch;
      int style;
      bit held_off;
      held_off   = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         style   = $urandom_range(0, 2);
         stretch = $urandom_range(20, 300);
         repeat (stretch) begin
            @(negedge clock);
            if (!held_off && frames_sent >= 300 && req_tvalid) begin
               held_off   = 1'b1;
               rsp_tready = 1'b0;
               repeat (HOLD_OFF_CYCLES) @(negedge clock);
            end
            case (style)
               0: rsp_tready = 1'b1;
               1: rsp_tready = 1'($urandom_range(0, 1));
               default: rsp_tready = ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int burst;
      bit steady;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      frames_sent = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // reset settings: unity gains, stereo, not recording
      send_frame(uniform_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0), MIC_PAIR, 0);
      send_frame(uniform_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0), MIC_MONO, 0);
      send_frame(uniform_frame(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFE, 1'b1), MIC_NONE, 0);

      // full gain: master peak saturates, both clamps hit
      drain_results();
      load_setup('1, '1, '1, '1, '1, '1, 1'b0, 1'b1);
      send_frame(uniform_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0), MIC_PAIR, 0);
      send_frame(uniform_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0), MIC_PAIR, 0);
      send_frame(uniform_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0), MIC_EXTRA, 0);
      send_frame(uniform_frame(16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0), MIC_MONO, 0);
      send_frame(uniform_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1), MIC_NONE, 0);
      send_frame(uniform_frame(16'h0100, 16'hFF00, 16'h0000, 16'h0000, 1'b0), MIC_PAIR, 0);

      // zero gains, mono
      drain_results();
      load_setup('0, '0, '0, '0, '0, '0, 1'b1, 1'b1);
      send_frame(uniform_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1), MIC_PAIR, 0);
      send_frame(uniform_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0), MIC_MONO, 0);
      send_frame(uniform_frame(16'h1234, 16'h5678, 16'h1234, 16'h5678, 1'b0), MIC_NONE, 0);

      // unity mono: rounding ties on the halved sums
      drain_results();
      load_setup(GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY,
                 1'b1, 1'b1);
      send_frame(uniform_frame(16'h0001, 16'h0000, 16'h0001, 16'h0000, 1'b1), MIC_PAIR, 0);
      send_frame(uniform_frame(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0), MIC_PAIR, 0);
      send_frame(uniform_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0), MIC_EXTRA, 0);
      send_frame(uniform_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0), MIC_MONO, 0);
      send_frame(uniform_frame(16'h0003, 16'h0000, 16'h0003, 16'h0000, 1'b0), MIC_MONO, 0);

      for (int phase = 0; phase < FRAME_PHASES; phase++) begin
         drain_results();
         load_setup(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                    pick_gain(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         steady = ($urandom_range(0, 3) == 0);
         burst  = 0;
         for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
            if (burst == 0)
               burst = $urandom_range(1, 24);
            burst--;
            send_frame(random_frame(), REQ_TUSER_W'($urandom_range(0, 3)),
                       (steady || burst != 0) ? 0 : $urandom_range(1, 12));
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("** audio_frame_mixer_with_meters: PASSED **");
      else
         $display("** audio_frame_mixer_with_meters: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/afm_pkg.sv
rtl/audio_frame_mixer_with_meters.sv
rtl/afm_checker.sv
bench/audio_frame_mixer_with_meters_checker.sv
bench/audio_frame_mixer_with_meters_tb.sv
